[rtl/akcr_pkg.sv]
package akcr_pkg;

    // Frame store geometry and key count.
    localparam int FRAME_DEPTH = 16;
    localparam int KEY_COUNT   = 8;
    localparam int IDX_W       = $clog2(FRAME_DEPTH);

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam logic REG_IDX_BOARD_ADDR = 1'b0;

    // Frame bytes and codes.
    localparam logic [7:0] START_CMD          = 8'hFA;
    localparam logic [7:0] END_MARK           = 8'hFF;
    localparam logic [7:0] START_DRIVE_REPLY  = 8'hFB;
    localparam logic [7:0] START_STATUS_REPLY = 8'hFC;
    localparam logic [7:0] DRIVE_TOP          = 8'h80;
    localparam logic [7:0] CMD_DRIVE          = 8'h01;
    localparam logic [7:0] CMD_STATUS         = 8'h02;
    localparam logic [7:0] KEY_LIMIT          = 8'(KEY_COUNT);
    localparam logic [7:0] KEY_MASK           = 8'((16'd1 << KEY_COUNT) - 16'd1);

    // Positions of the bytes within a reply.
    localparam logic [2:0] POS_START = 3'd0;
    localparam logic [2:0] POS_ADDR  = 3'd1;
    localparam logic [2:0] POS_CMD   = 3'd2;
    localparam logic [2:0] POS_KEY   = 3'd3;
    localparam logic [2:0] POS_LEVEL = 3'd4;
    localparam logic [2:0] POS_END   = 3'd5;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
        logic [7:0] key_levels;
    } akcr_in_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_last;
        logic [7:0] drive_word;
        logic       drive_strobe;
    } akcr_out_t;

    // One accepted command, as the back end needs it.
    typedef struct packed {
        logic       is_drive;
        logic [7:0] addr;
        logic [7:0] key;
        logic [7:0] level;
    } akcr_cmd_t;

    typedef struct packed {
        logic      push;
        akcr_cmd_t cmd;
    } akcr_push_t;

    typedef struct packed {
        logic      valid;
        akcr_cmd_t cmd;
    } akcr_head_t;

endpackage

[rtl/akcr_front.sv]
module akcr_front
    import akcr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [3:0] board_address,
    input  logic       accept,
    input  akcr_in_t   item,
    output akcr_push_t push_out
);

    logic [7:0]       store_reg [FRAME_DEPTH];
    logic [IDX_W-1:0] write_index_reg;
    logic [IDX_W-1:0] write_index_next;
    logic             frame_ok;
    logic             key_ok;

    // Write index wraps at the end of the store and restarts on each frame gap.
    always_comb
    begin
        write_index_next = write_index_reg;
        if (accept)
        begin
            if (item.req_type)
                write_index_next = '0;
            else if (write_index_reg == IDX_W'(FRAME_DEPTH - 1))
                write_index_next = '0;
            else
                write_index_next = write_index_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_index_reg <= '0;
            for (int i = 0; i < FRAME_DEPTH; i++)
                store_reg[i] <= '0;
        end
        else
        begin
            write_index_reg <= write_index_next;
            if (accept && !item.req_type)
                store_reg[write_index_reg] <= item.rx_byte;
        end
    end

    // Check the frame header and trailer and classify the command.
    assign frame_ok = (store_reg[0] == START_CMD) &&
                      (store_reg[1] == {4'b0, board_address}) &&
                      (store_reg[4] == END_MARK);
    assign key_ok   = (store_reg[3] < KEY_LIMIT);

    always_comb
    begin
        push_out.cmd.addr     = store_reg[1];
        push_out.cmd.is_drive = (store_reg[2] == CMD_DRIVE);
        push_out.push         = 1'b0;
        if (store_reg[2] == CMD_DRIVE)
        begin
            push_out.cmd.key   = store_reg[3];
            push_out.cmd.level = {7'b0, item.key_levels[store_reg[3][2:0]]};
        end
        else
        begin
            push_out.cmd.key   = '0;
            push_out.cmd.level = item.key_levels & KEY_MASK;
        end
        if (accept && item.req_type && frame_ok)
        begin
            if (store_reg[2] == CMD_DRIVE)
                push_out.push = key_ok;
            else if (store_reg[2] == CMD_STATUS)
                push_out.push = 1'b1;
        end
    end

endmodule

[rtl/akcr_queue.sv]
module akcr_queue
    import akcr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  akcr_push_t push_in,
    input  logic       pop,
    output akcr_head_t head,
    output logic       full
);

    akcr_cmd_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_push = push_in.push && !full;
    assign do_pop  = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.cmd   = entry_reg[rd_ptr_reg];

    // Pointer and occupancy bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_in.cmd;
    end

endmodule

[rtl/akcr_back.sv]
module akcr_back
    import akcr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  akcr_head_t head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output akcr_out_t  out_item
);

    logic       out_valid_reg;
    akcr_out_t  out_item_reg;
    logic [2:0] pos_reg;
    logic [2:0] pos_next;
    logic       load;
    akcr_out_t  item_next;

    // The output register takes a new byte when it is empty or being taken.
    assign load = head.valid && (!out_valid_reg || !out_stall);
    assign pop  = load && (pos_reg == POS_END);

    always_comb
    begin
        pos_next = pos_reg;
        if (load)
            pos_next = (pos_reg == POS_END) ? POS_START : pos_reg + 1'b1;
    end

    // Build the reply byte at the current position.
    always_comb
    begin
        item_next.tx_last      = (pos_reg == POS_END);
        item_next.drive_strobe = head.cmd.is_drive && (pos_reg == POS_START);
        item_next.drive_word   = head.cmd.is_drive ?
                                 (DRIVE_TOP >> head.cmd.key[2:0]) : '0;
        case (pos_reg)
            POS_START: item_next.tx_byte = head.cmd.is_drive ?
                                           START_DRIVE_REPLY : START_STATUS_REPLY;
            POS_ADDR:  item_next.tx_byte = head.cmd.addr;
            POS_CMD:   item_next.tx_byte = head.cmd.is_drive ? CMD_DRIVE : '0;
            POS_KEY:   item_next.tx_byte = head.cmd.key;
            POS_LEVEL: item_next.tx_byte = head.cmd.level;
            POS_END:   item_next.tx_byte = END_MARK;
            default:   item_next.tx_byte = END_MARK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_reg       <= POS_START;
        end
        else
        begin
            pos_reg <= pos_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_item_reg <= item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

[rtl/addressed_key_command_responder_unit.sv]
// Addressed key command responder.
// Input channel (in_valid, in_stall, in_item): one item per received byte, or a
// frame gap item that ends the frame. An item is taken when in_valid is high and
// in_stall is low. Byte items are stored in a wrapping frame store; a frame gap
// item checks start, board address and end mark and queues a command.
// Output channel (out_valid, out_stall, out_item): a valid command produces six
// reply bytes, the last marked by tx_last; a drive command also carries the
// one-hot drive word, with drive_strobe on its first byte.
// Throughput: one input item per cycle unless in_stall. The back end serializer
// sets the reply rate: one byte per cycle unless out_stall. A taken frame gap
// item's command is queued, then its first byte fills the output register.
// in_stall rises only when the two-entry command queue is full, so a receiver
// that stalls the output eventually holds up the input.
// Reset clears the frame store to zero, the write index, the board address and
// the queue. board_address is written over the APB port at byte address 0.
module addressed_key_command_responder_unit
    import akcr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  akcr_in_t           in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output akcr_out_t          out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [3:0] board_address_reg;
    logic       accept;
    logic       queue_full;
    logic       pop;
    akcr_push_t push;
    akcr_head_t head;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IDX_BOARD_ADDR) ? {28'b0, board_address_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            board_address_reg <= '0;
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_IDX_BOARD_ADDR))
            board_address_reg <= pwdata[3:0];
    end

    // Input handshake.
    assign in_stall = queue_full;
    assign accept   = in_valid && !in_stall;

    akcr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .board_address (board_address_reg),
        .accept        (accept),
        .item          (in_item),
        .push_out      (push)
    );

    akcr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_in (push),
        .pop     (pop),
        .head    (head),
        .full    (queue_full)
    );

    akcr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
